[rtl/core/lfire_pkg.sv]
// lfire_pkg: shared types, constants and mask tables of the fire effect core
// used by every module under rtl/core except lfire_checker; depends on nothing else
package lfire_pkg;

  localparam int COLUMNS   = 8;
  localparam int ROWS      = 15;
  localparam int ROW_W     = COLUMNS * 8;
  localparam int COL_IDX_W = $clog2(COLUMNS);
  localparam int ROW_IDX_W = $clog2(ROWS);

  localparam logic [7:0] PHASE_FULL = 8'd100;
  // 2^22 / 100 rounded up, exact quotient for sums up to 25500
  localparam logic [15:0] RECIP       = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  localparam logic [6:0] PHASE_STEP_RESET = 7'd25;
  localparam logic [7:0] HUE_BASE_RESET   = 8'd8;

  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0,
    REG_HUE_BASE   = 1'b1
  } cfg_reg_t;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic shift;   // frame advance: rows move up, seed enters row 0
    logic rotate;  // ring step while rows are drawn
  } heat_ctrl_t;

  // every mask row is mirror symmetric, so byte order within the concat is moot
  function automatic row_t value_mask_row(input logic [ROW_IDX_W-1:0] y);
    row_t r;
    case (y)
      4'd0:    r = {8'd32, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd32};
      4'd1:    r = {8'd64, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd64};
      4'd2:    r = {8'd96, 8'd32, 8'd0, 8'd0, 8'd0, 8'd0, 8'd32, 8'd96};
      4'd3:    r = {8'd128, 8'd64, 8'd32, 8'd0, 8'd0, 8'd32, 8'd64, 8'd128};
      4'd4:    r = {8'd160, 8'd96, 8'd64, 8'd32, 8'd32, 8'd64, 8'd96, 8'd160};
      4'd5:    r = {8'd192, 8'd128, 8'd96, 8'd64, 8'd64, 8'd96, 8'd128, 8'd192};
      4'd6:    r = {8'd255, 8'd160, 8'd128, 8'd96, 8'd96, 8'd128, 8'd160, 8'd255};
      4'd7:    r = {8'd255, 8'd192, 8'd160, 8'd128, 8'd128, 8'd160, 8'd192, 8'd255};
      4'd8:    r = {8'd255, 8'd220, 8'd185, 8'd150, 8'd150, 8'd185, 8'd220, 8'd255};
      4'd9:    r = {8'd255, 8'd255, 8'd220, 8'd185, 8'd185, 8'd220, 8'd255, 8'd255};
      4'd10:   r = {8'd255, 8'd255, 8'd255, 8'd220, 8'd220, 8'd255, 8'd255, 8'd255};
      default: r = {COLUMNS{8'd255}};
    endcase
    return r;
  endfunction

  function automatic row_t hue_mask_row(input logic [ROW_IDX_W-1:0] y);
    row_t r;
    case (y)
      4'd0:    r = {8'd1, 8'd8, 8'd16, 8'd24, 8'd24, 8'd16, 8'd8, 8'd1};
      4'd1:    r = {8'd1, 8'd8, 8'd16, 8'd20, 8'd20, 8'd16, 8'd8, 8'd1};
      4'd2:    r = {8'd1, 8'd8, 8'd13, 8'd19, 8'd19, 8'd13, 8'd8, 8'd1};
      4'd3:    r = {8'd1, 8'd5, 8'd11, 8'd13, 8'd13, 8'd11, 8'd5, 8'd1};
      4'd4:    r = {8'd1, 8'd5, 8'd11, 8'd11, 8'd11, 8'd11, 8'd5, 8'd1};
      4'd5:    r = {8'd0, 8'd1, 8'd5, 8'd8, 8'd8, 8'd5, 8'd1, 8'd0};
      4'd6:    r = {8'd0, 8'd0, 8'd1, 8'd5, 8'd5, 8'd1, 8'd0, 8'd0};
      4'd7:    r = {8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // hue base plus mask, each byte wrapping on its own
  function automatic row_t row_hues(input logic [7:0] base, input logic [ROW_IDX_W-1:0] y);
    row_t m;
    row_t r;
    m = hue_mask_row(y);
    for (int x = 0; x < COLUMNS; x++) begin
      r[8*x +: 8] = base + m[8*x +: 8];
    end
    return r;
  endfunction

endpackage

[rtl/core/lfire_blend.sv]
// lfire_blend: shared column unit, phase blend of two heat bytes,
// divide by 100 through a reciprocal and mask subtract with clamp; uses lfire_pkg
module lfire_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue,
  input  logic [lfire_pkg::COL_IDX_W-1:0] col_in,
  input  logic [7:0]                    upper,
  input  logic [7:0]                    lower,
  input  logic [6:0]                    phase,
  input  logic [7:0]                    mask,
  output logic                          res_valid,
  output logic [lfire_pkg::COL_IDX_W-1:0] res_col,
  output logic [7:0]                    res_value
);
  import lfire_pkg::*;

  logic [6:0]  weight_up;
  logic [14:0] sum_next;
  logic [14:0] sum;
  logic [7:0]  mask_q;
  logic [30:0] scaled;
  logic [7:0]  quot;

  assign weight_up = 7'(PHASE_FULL - {1'b0, phase});
  assign sum_next  = 15'(weight_up * upper) + 15'(phase * lower);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= issue;
    end
    sum     <= sum_next;
    mask_q  <= mask;
    res_col <= col_in;
  end

  assign scaled    = 31'(sum * RECIP);
  assign quot      = scaled[RECIP_SHIFT +: 8];
  assign res_value = (quot > mask_q) ? 8'(quot - mask_q) : 8'd0;

endmodule

[rtl/core/lfire_heat.sv]
// lfire_heat: heat rows as a ring of row registers plus the held seed line;
// shifts on frame advance and rotates one row per drawn row; uses lfire_pkg
module lfire_heat (
  input  logic                  clk,
  input  logic                  rst,
  input  lfire_pkg::heat_ctrl_t ctrl,
  input  lfire_pkg::row_t       random_line,
  output lfire_pkg::row_t       top_row,
  output lfire_pkg::row_t       below_row,
  output lfire_pkg::row_t       seed_row
);
  import lfire_pkg::*;

  row_t rows [ROWS];
  row_t seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < ROWS; y++) begin
        rows[y] <= '0;
      end
      seed <= '0;
    end else if (ctrl.shift || ctrl.rotate) begin
      for (int y = 1; y < ROWS; y++) begin
        rows[y] <= rows[y-1];
      end
      if (ctrl.shift) begin
        rows[0] <= seed;
        seed    <= random_line;
      end else begin
        rows[0] <= rows[ROWS-1];
      end
    end
  end

  // after k rotations the top tap holds row ROWS-1-k
  assign top_row   = rows[ROWS-1];
  assign below_row = rows[ROWS-2];
  assign seed_row  = seed;

endmodule

[rtl/core/led_fire_effect_frame_core.sv]
// led_fire_effect_frame_core: top level, frame sequencer around the heat ring
// and the shared column blend unit; uses lfire_pkg, lfire_heat, lfire_blend
//
// Usage:
//   s_* channel: one word per frame tick, tdata = eight random heat bytes.
//   m_* channel: fifteen words per tick, top row (14) first, row 0 last with
//   tlast high. m_tdata holds row index, brightness bytes and hue bytes.
//   cfg_*: write phase step (index 0) and hue base (index 1) while idle.
// Timing:
//   The single column unit handles one byte a cycle, so a row is issued
//   column by column in the calc state, then passes the drain state and
//   waits in the output state until a ready receiver takes it. s_tready
//   is high only while no frame is in progress.
// Reset:
//   rst (synchronous) clears the heat rows, seed line and blend phase and
//   loads the register defaults; no words are pending afterwards.
// Stall:
//   a row word is held in the output registers until taken; the next row is
//   computed only after that, so backpressure stretches the frame.
module led_fire_effect_frame_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] random_line
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // [3:0] row_index, [67:4] row_values, [131:68] row_hues
  output logic         m_tlast,   // last_row
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  import lfire_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  state_t               state;
  logic [7:0]           blend_phase;
  logic [6:0]           phase_step;
  logic [7:0]           hue_base;
  logic [ROW_IDX_W-1:0] row;
  logic [COL_IDX_W-1:0] col;
  row_t                 vals;
  row_t                 hues;

  heat_ctrl_t           heat_ctrl;
  row_t                 top_row;
  row_t                 below_row;
  row_t                 seed_row;
  row_t                 lower_row;
  row_t                 mask_row;

  logic                 in_fire;
  logic                 out_fire;
  logic                 issue;
  logic                 res_valid;
  logic [COL_IDX_W-1:0] res_col;
  logic [7:0]           res_value;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign issue    = (state == ST_CALC);

  assign heat_ctrl.shift  = in_fire && (blend_phase >= PHASE_FULL);
  assign heat_ctrl.rotate = out_fire;

  lfire_heat u_heat (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (heat_ctrl),
    .random_line(s_tdata),
    .top_row    (top_row),
    .below_row  (below_row),
    .seed_row   (seed_row)
  );

  // row 0 blends against the seed line and takes no mask
  assign lower_row = (row == '0) ? seed_row : below_row;
  assign mask_row  = (row == '0) ? '0 : value_mask_row(row);

  lfire_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .col_in   (col),
    .upper    (top_row[8*col +: 8]),
    .lower    (lower_row[8*col +: 8]),
    .phase    (blend_phase[6:0]),
    .mask     (mask_row[8*col +: 8]),
    .res_valid(res_valid),
    .res_col  (res_col),
    .res_value(res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      blend_phase <= '0;
      phase_step  <= PHASE_STEP_RESET;
      hue_base    <= HUE_BASE_RESET;
      m_tvalid    <= 1'b0;
      row         <= '0;
      col         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP: phase_step <= cfg_data[6:0];
          REG_HUE_BASE:   hue_base   <= cfg_data;
          default:        ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (blend_phase >= PHASE_FULL) begin
              blend_phase <= '0;
            end
            row   <= ROW_IDX_W'(ROWS - 1);
            col   <= '0;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          col <= col + 1'b1;
          if (col == COL_IDX_W'(COLUMNS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last column lands this cycle
          m_tvalid <= 1'b1;
          hues     <= row_hues(hue_base, row);
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_fire) begin
            m_tvalid <= 1'b0;
            col      <= '0;
            if (row == '0) begin
              blend_phase <= blend_phase + {1'b0, phase_step};
              state       <= ST_IDLE;
            end else begin
              row   <= row - 1'b1;
              state <= ST_CALC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (res_valid) begin
      vals[8*res_col +: 8] <= res_value;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {4'd0, hues, vals, row};
  assign m_tlast  = (row == '0);

endmodule

[rtl/core/lfire_checker.sv]
// lfire_checker: port-level assertions for led_fire_effect_frame_core
// bound to the top level below; uses only the top level's ports
module lfire_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata,
  input logic         m_tlast
);

  // a tick is never taken while a row word is pending
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while row word pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
    else $error("block not busy after tick accepted");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after last row of frame");

  a_row_gap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !m_tvalid)
    else $error("next row word shown without compute gap");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled row word changed");

endmodule

bind led_fire_effect_frame_core lfire_checker u_lfire_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
